// ===== rtl/bfc_pkg.sv =====
// Shared constants, types and command/status structs for the box frustum cull tester.
package bfc_pkg;

  // Fixed-point format of matrix entries and box bounds
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 32;

  // Input is taken as its low VALUE_BITS bits (zero-extended when wider than the port)
  localparam int EXT_W  = (VALUE_BITS > IN_W) ? VALUE_BITS : IN_W;
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam int TERM_W = (PROD_W > VALUE_BITS + FRAC_BITS) ? PROD_W : VALUE_BITS + FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;
  localparam int CMP_W  = SUM_W + 1;

  localparam int ROWS       = 4;
  localparam int COLS       = 4;
  localparam int CORNERS    = 8;
  localparam int CNT_W      = $clog2(CORNERS);
  localparam int PIPE_DEPTH = 3;
  localparam int DRN_W      = $clog2(PIPE_DEPTH);
  localparam int CODE_W     = 6;
  localparam int FLAG_W     = 4;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TEST = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ACT_KEEP  = 2'd0,
    ACT_CULL  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Object flag bit positions
  localparam int FLG_ALWAYS = 0;
  localparam int FLG_HIDDEN = 1;
  localparam int FLG_DONT   = 2;
  localparam int FLG_EMPTY  = 3;

  // Clip code bits
  localparam logic [CODE_W-1:0] CLIP_YLO = 6'h08;
  localparam logic [CODE_W-1:0] CLIP_YHI = 6'h04;
  localparam logic [CODE_W-1:0] CLIP_ZHI = 6'h20;
  localparam logic [CODE_W-1:0] CLIP_ZLO = 6'h10;
  localparam logic [CODE_W-1:0] CLIP_XLO = 6'h02;
  localparam logic [CODE_W-1:0] CLIP_XHI = 6'h01;

  typedef struct packed {
    logic             load;     // write one matrix row from the input ports
    logic             capture;  // latch box and flags, preset the code AND
    logic             issue;    // push one corner into the pipeline
    logic [CNT_W-1:0] corner;
  } cmd_t;

  typedef struct packed {
    logic skip;  // flags on the input ports settle the result without a box test
  } status_t;

endpackage

// ===== rtl/box_frustum_cull_test_unit.sv =====
// Top level of the box frustum cull tester: controller plus transform datapath.
//
// A transfer is taken on a rising edge with start high and busy low. With
// in_func low it writes one row (in_row) of the 4x4 object-to-clip matrix from
// in_v0..in_v3 on the transfer edge and gives no result. With in_func high it
// tests the box (in_v0..in_v2 min, in_v3..in_v5 max) against the view volume
// and returns one result, strobed by out_valid for exactly one cycle; the
// receiver cannot stall, so take out_cull_action and out_clip_and on that edge.
// A test that the object flags settle (hidden or dont cull without always cull,
// or an empty box) raises out_valid in the cycle after the transfer. In a full
// test one corner per cycle enters the four-row multiply-accumulate pipeline
// (eight corners), and the corners pass the pipeline registers (products, pair
// sums, row sums) before the clip code AND is final. Matrix entries read before
// being written give unspecified results; load all four rows first.
module box_frustum_cull_test_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [1:0]         in_row,
  input  logic signed [31:0] in_v0,
  input  logic signed [31:0] in_v1,
  input  logic signed [31:0] in_v2,
  input  logic signed [31:0] in_v3,
  input  logic signed [31:0] in_v4,
  input  logic signed [31:0] in_v5,
  input  logic [3:0]         in_object_flags,
  output logic               out_valid,
  output logic [1:0]         out_cull_action,
  output logic [5:0]         out_clip_and
);
  import bfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing: transfer accept, corner walk, drain, result strobe
  bfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Matrix store and corner transform / clip compare pipeline
  bfc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_row          (in_row),
    .in_v0           (in_v0),
    .in_v1           (in_v1),
    .in_v2           (in_v2),
    .in_v3           (in_v3),
    .in_v4           (in_v4),
    .in_v5           (in_v5),
    .in_object_flags (in_object_flags),
    .out_cull_action (out_cull_action),
    .out_clip_and    (out_clip_and)
  );

endmodule

// ===== rtl/bfc_ctrl.sv =====
// Sequencer for the cull tester: accepts transfers, walks the corners, strobes the result.
module bfc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_func,
  input  bfc_pkg::status_t status,
  output logic             busy,
  output logic             out_valid,
  output bfc_pkg::cmd_t    cmd
);
  import bfc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DRN_W-1:0] drn_r, drn_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drn_r   <= drn_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    drn_nxt     = drn_r;
    busy        = 1'b1;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.capture = 1'b0;
    cmd.issue   = 1'b0;
    cmd.corner  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (func_t'(in_func) == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = status.skip ? ST_OUT : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORNERS - 1)) begin
          drn_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drn_nxt = drn_r + 1'b1;
        if (drn_r == DRN_W'(PIPE_DEPTH - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_test_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func) |=> busy)
    else $error("test transfer did not raise busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_eight_corners: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.corner == CNT_W'(CORNERS - 1)) |=> !cmd.issue)
    else $error("corner issue ran past the last corner");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy && !cmd.issue)
    else $error("matrix row written while a test was running");
`endif

endmodule

// ===== rtl/bfc_dpath.sv =====
// Matrix store, four-row corner transform pipeline, clip code compare and result mux.
module bfc_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfc_pkg::cmd_t                 cmd,
  output bfc_pkg::status_t              status,
  input  logic [1:0]                    in_row,
  input  logic signed [31:0]            in_v0,
  input  logic signed [31:0]            in_v1,
  input  logic signed [31:0]            in_v2,
  input  logic signed [31:0]            in_v3,
  input  logic signed [31:0]            in_v4,
  input  logic signed [31:0]            in_v5,
  input  logic [3:0]                    in_object_flags,
  output logic [1:0]                    out_cull_action,
  output logic [bfc_pkg::CODE_W-1:0]    out_clip_and
);
  import bfc_pkg::*;

  function automatic logic signed [VALUE_BITS-1:0] to_val(input logic [IN_W-1:0] x);
    logic [EXT_W-1:0] e;
    e = EXT_W'(x);
    return e[VALUE_BITS-1:0];
  endfunction

  // Flag precedence: hidden, then dont cull, each unless always cull is set; then empty box.
  function automatic logic [2:0] flag_decode(input logic [FLAG_W-1:0] f);
    logic       skip;
    logic [1:0] act;
    skip = 1'b1;
    act  = ACT_CLEAR;
    priority if (!f[FLG_ALWAYS] && f[FLG_HIDDEN]) begin
      act = ACT_KEEP;
    end else if (!f[FLG_ALWAYS] && f[FLG_DONT]) begin
      act = ACT_CLEAR;
    end else if (f[FLG_EMPTY]) begin
      act = ACT_CLEAR;
    end else begin
      skip = 1'b0;
    end
    return {skip, act};
  endfunction

  logic signed [VALUE_BITS-1:0] mat_r [ROWS][COLS];
  logic signed [VALUE_BITS-1:0] lo_r  [3];
  logic signed [VALUE_BITS-1:0] hi_r  [3];

  logic signed [VALUE_BITS-1:0] pt    [3];
  logic signed [PROD_W-1:0]     prod  [ROWS][3];
  logic signed [TERM_W-1:0]     prod_r[ROWS][3];
  logic signed [TERM_W-1:0]     tr_r  [ROWS];
  logic signed [SUM_W-1:0]      s01_r [ROWS];
  logic signed [SUM_W-1:0]      s23_r [ROWS];
  logic signed [SUM_W-1:0]      h_r   [ROWS];
  logic                         v1_r, v2_r, v3_r;
  logic [CODE_W-1:0]            acc_r;
  logic [CODE_W-1:0]            code;
  logic [2:0]                   dec_in, dec_r;

  logic signed [CMP_W-1:0] hx, hy, hz, hw;
  logic signed [CMP_W-1:0] xp, xm, yp, ym, zm;

  assign dec_in      = flag_decode(in_object_flags);
  assign status.skip = dec_in[2];

  // Corner select: bit 2 picks max x, bit 1 max y, bit 0 max z
  assign pt[0] = cmd.corner[2] ? hi_r[0] : lo_r[0];
  assign pt[1] = cmd.corner[1] ? hi_r[1] : lo_r[1];
  assign pt[2] = cmd.corner[0] ? hi_r[2] : lo_r[2];

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = PROD_W'(pt[c]) * PROD_W'(mat_r[r][c]);
      end
    end
  end

  // Matrix rows and captured box
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mat_r[in_row][0] <= to_val(in_v0);
      mat_r[in_row][1] <= to_val(in_v1);
      mat_r[in_row][2] <= to_val(in_v2);
      mat_r[in_row][3] <= to_val(in_v3);
    end
    if (cmd.capture) begin
      lo_r[0] <= to_val(in_v0);
      lo_r[1] <= to_val(in_v1);
      lo_r[2] <= to_val(in_v2);
      hi_r[0] <= to_val(in_v3);
      hi_r[1] <= to_val(in_v4);
      hi_r[2] <= to_val(in_v5);
      dec_r   <= dec_in;
    end
  end

  // Transform pipeline: products, pair sums, row sums
  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= TERM_W'(prod[r][c]);
      end
      tr_r[r]  <= TERM_W'(mat_r[r][3]) <<< FRAC_BITS;
      s01_r[r] <= SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]);
      s23_r[r] <= SUM_W'(prod_r[r][2]) + SUM_W'(tr_r[r]);
      h_r[r]   <= s01_r[r] + s23_r[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Clip code for the corner leaving the row-sum stage
  always_comb begin
    hx   = CMP_W'(h_r[0]);
    hy   = CMP_W'(h_r[1]);
    hz   = CMP_W'(h_r[2]);
    hw   = CMP_W'(h_r[3]);
    xp   = hx + hw;
    xm   = hx - hw;
    yp   = hy + hw;
    ym   = hy - hw;
    zm   = hz - hw;
    code = '0;
    if (yp[CMP_W-1]) begin
      code = code | CLIP_YLO;
    end else if (!ym[CMP_W-1] && (ym != '0)) begin
      code = code | CLIP_YHI;
    end
    if (!zm[CMP_W-1] && (zm != '0)) begin
      code = code | CLIP_ZHI;
    end else if (hz[CMP_W-1]) begin
      code = code | CLIP_ZLO;
    end
    if (xp[CMP_W-1]) begin
      code = code | CLIP_XLO;
    end else if (!xm[CMP_W-1] && (xm != '0)) begin
      code = code | CLIP_XHI;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_r <= '1;
    end else if (v3_r) begin
      acc_r <= acc_r & code;
    end
  end

  // Result: skipped tests report the flag action with a zero code
  always_comb begin
    if (dec_r[2]) begin
      out_cull_action = dec_r[1:0];
      out_clip_and    = '0;
    end else begin
      out_cull_action = (acc_r != '0) ? ACT_CULL : ACT_CLEAR;
      out_clip_and    = acc_r;
    end
  end

endmodule

// ===== verif/bfc_cull_checker.sv =====
// Transfer monitor, cull verdict predictor and result comparison for the box frustum cull tester.
module bfc_cull_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_func,
  input  logic [1:0]         in_row,
  input  logic signed [31:0] in_v0,
  input  logic signed [31:0] in_v1,
  input  logic signed [31:0] in_v2,
  input  logic signed [31:0] in_v3,
  input  logic signed [31:0] in_v4,
  input  logic signed [31:0] in_v5,
  input  logic [3:0]         in_object_flags,
  input  logic               out_valid,
  input  logic [1:0]         out_cull_action,
  input  logic [5:0]         out_clip_and,
  output int                 errors,
  output int                 outstanding
);
  import bfc_pkg::*;

  // Wide enough for three full products plus the shifted translation and a w difference
  localparam int ACC_W = 2 * VALUE_BITS + 8;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    act_t              action;
    logic [CODE_W-1:0] clip;
  } verdict_t;

  logic signed [VALUE_BITS-1:0] clip_rows [ROWS][COLS];
  verdict_t                     pending_verdicts [$];
  verdict_t                     want;
  int                           error_count = 0;
  int                           pending_count = 0;

  assign errors      = error_count;
  assign outstanding = pending_count;

  function automatic acc_t row_dot(int r, acc_t x, acc_t y, acc_t z);
    acc_t m0, m1, m2, m3;
    m0 = clip_rows[r][0];
    m1 = clip_rows[r][1];
    m2 = clip_rows[r][2];
    m3 = clip_rows[r][3];
    return m0 * x + m1 * y + m2 * z + (m3 <<< FRAC_BITS);
  endfunction

  function automatic logic [CODE_W-1:0] corner_outcode(acc_t x, acc_t y, acc_t z);
    acc_t              hx, hy, hz, hw;
    logic [CODE_W-1:0] c;
    hx = row_dot(ROW_X, x, y, z);
    hy = row_dot(ROW_Y, x, y, z);
    hz = row_dot(ROW_Z, x, y, z);
    hw = row_dot(ROW_W, x, y, z);
    c  = '0;
    if (hy + hw < 0) c = CLIP_YLO;
    else if (hy - hw > 0) c = CLIP_YHI;
    if (hz - hw > 0) c |= CLIP_ZHI;
    else if (hz < 0) c |= CLIP_ZLO;
    if (hx + hw < 0) c |= CLIP_XLO;
    else if (hx - hw > 0) c |= CLIP_XHI;
    return c;
  endfunction

  function automatic verdict_t cull_verdict(logic [FLAG_W-1:0] flags,
                                            logic signed [VALUE_BITS-1:0] lo_x,
                                            logic signed [VALUE_BITS-1:0] lo_y,
                                            logic signed [VALUE_BITS-1:0] lo_z,
                                            logic signed [VALUE_BITS-1:0] hi_x,
                                            logic signed [VALUE_BITS-1:0] hi_y,
                                            logic signed [VALUE_BITS-1:0] hi_z);
    verdict_t          v;
    logic [CODE_W-1:0] code;
    acc_t              x, y, z;
    v.action = ACT_KEEP;
    v.clip   = '0;
    // always cull overrides hidden and dont cull
    if (!flags[FLG_ALWAYS] && flags[FLG_HIDDEN]) return v;
    v.action = ACT_CLEAR;
    if (!flags[FLG_ALWAYS] && flags[FLG_DONT]) return v;
    if (flags[FLG_EMPTY]) return v;
    code = '1;
    for (int i = 0; i < CORNERS; i++) begin
      x = (i & 4) ? hi_x : lo_x;
      y = (i & 2) ? hi_y : lo_y;
      z = (i & 1) ? hi_z : lo_z;
      code &= corner_outcode(x, y, z);
    end
    v.action = (code != '0) ? ACT_CULL : ACT_CLEAR;
    v.clip   = code;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // compare before queueing: a result never belongs to the transfer on the same edge
      if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: result with nothing pending, expected none actual action %0d clip %h",
                   $time, out_cull_action, out_clip_and);
          error_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_cull_action !== want.action) begin
            $display("%0t: cull action expected %0d actual %0d",
                     $time, want.action, out_cull_action);
            error_count++;
          end
          if (out_clip_and !== want.clip) begin
            $display("%0t: clip AND expected %h actual %h", $time, want.clip, out_clip_and);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_func == FUNC_LOAD) begin
          clip_rows[in_row][0] = in_v0;
          clip_rows[in_row][1] = in_v1;
          clip_rows[in_row][2] = in_v2;
          clip_rows[in_row][3] = in_v3;
        end else begin
          pending_verdicts.push_back(cull_verdict(in_object_flags, in_v0, in_v1, in_v2,
                                                  in_v3, in_v4, in_v5));
        end
      end
      pending_count = pending_verdicts.size();
    end
  end

endmodule

// ===== verif/box_frustum_cull_test_unit_tb.sv =====
// Stimulus and final verdict for the box frustum cull tester.
module box_frustum_cull_test_unit_tb;
  import bfc_pkg::*;

  // Q16.16 constants used to place boxes around an identity view volume
  localparam logic signed [31:0] ONE      = 32'sh0001_0000;
  localparam logic signed [31:0] HALF     = 32'sh0000_8000;
  localparam logic signed [31:0] QUARTER  = 32'sh0000_4000;
  localparam logic signed [31:0] TWO      = 32'sh0002_0000;
  localparam logic signed [31:0] THREE    = 32'sh0003_0000;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

  localparam logic [3:0] F_NONE   = 4'd0;
  localparam logic [3:0] F_ALWAYS = 4'(1 << FLG_ALWAYS);
  localparam logic [3:0] F_HIDDEN = 4'(1 << FLG_HIDDEN);
  localparam logic [3:0] F_DONT   = 4'(1 << FLG_DONT);
  localparam logic [3:0] F_EMPTY  = 4'(1 << FLG_EMPTY);

  localparam int RANDOM_ITEMS  = 600;
  localparam int QUIET_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 24;
  // Room for about 625 items, each with its busy time and the longest sender gap
  localparam int CYCLE_LIMIT   = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_func = FUNC_LOAD;
  logic [1:0]         in_row = '0;
  logic signed [31:0] in_v0 = '0;
  logic signed [31:0] in_v1 = '0;
  logic signed [31:0] in_v2 = '0;
  logic signed [31:0] in_v3 = '0;
  logic signed [31:0] in_v4 = '0;
  logic signed [31:0] in_v5 = '0;
  logic [3:0]         in_object_flags = '0;
  logic               out_valid;
  logic [1:0]         out_cull_action;
  logic [5:0]         out_clip_and;

  int fail_count;
  int verdicts_due;
  int cycle_count = 0;
  int items_sent = 0;
  bit idle_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_frustum_cull_test_unit i_dut (.*);

  bfc_cull_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_func, .in_row,
    .in_v0, .in_v1, .in_v2, .in_v3, .in_v4, .in_v5, .in_object_flags,
    .out_valid, .out_cull_action, .out_clip_and,
    .errors      (fail_count),
    .outstanding (verdicts_due)
  );

  // Hard stop for a hung handshake or a result that never shows up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_frustum_cull_test_unit_tb: done, errors");
      $finish;
    end
  end

  // Present one item and hold it until the block takes the transfer. Keep
  // start high straight into the next item unless an idle burst is drawn.
  task automatic transfer(input func_t f, input logic [1:0] r,
                          input logic signed [31:0] a0, input logic signed [31:0] a1,
                          input logic signed [31:0] a2, input logic signed [31:0] a3,
                          input logic signed [31:0] a4, input logic signed [31:0] a5,
                          input logic [3:0] fl);
    in_func         <= f;
    in_row          <= r;
    in_v0           <= a0;
    in_v1           <= a1;
    in_v2           <= a2;
    in_v3           <= a3;
    in_v4           <= a4;
    in_v5           <= a5;
    in_object_flags <= fl;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (idle_on && $urandom_range(2) == 0) begin
      start <= 1'b0;
      // sometimes let the block finish first so the gap lands after busy drops
      if ($urandom_range(1) == 1) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_row(input logic [1:0] r, input logic signed [31:0] c0,
                          input logic signed [31:0] c1, input logic signed [31:0] c2,
                          input logic signed [31:0] c3);
    // columns 4 and 5 and the flags are ignored on a load; toggle them anyway
    transfer(FUNC_LOAD, r, c0, c1, c2, c3, $urandom, $urandom, 4'($urandom_range(15)));
  endtask

  task automatic box_test(input logic [3:0] fl,
                          input logic signed [31:0] lx, input logic signed [31:0] ly,
                          input logic signed [31:0] lz, input logic signed [31:0] hx,
                          input logic signed [31:0] hy, input logic signed [31:0] hz);
    transfer(FUNC_TEST, 2'($urandom_range(3)), lx, ly, lz, hx, hy, hz, fl);
  endtask

  // Uniform Q16.16 value in [-span, span]
  function automatic logic signed [31:0] q16_within(int unsigned span);
    return 32'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  // Full-range word with the extremes drawn often
  function automatic logic signed [31:0] any_word();
    unique case ($urandom_range(7))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // A sane row keeps entries within +-2.0 with a positive w translation so
  // boxes land on both sides of the planes; a wild row is full range.
  task automatic random_row(input bit wild, input logic [1:0] r);
    logic signed [31:0] c [4];
    for (int k = 0; k < 4; k++) c[k] = wild ? any_word() : q16_within(TWO);
    if (!wild && r == 2'(ROWS - 1)) c[3] = 32'($urandom_range(HALF, 4 * ONE));
    load_row(r, c[0], c[1], c[2], c[3]);
  endtask

  task automatic random_box(input bit wild);
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] mid, half_ext, swap;
    logic [3:0]         fl;
    for (int a = 0; a < 3; a++) begin
      if (wild) begin
        lo[a] = any_word();
        hi[a] = any_word();
      end else begin
        mid      = q16_within(4 * ONE);
        half_ext = 32'($urandom_range(ONE));
        lo[a]    = mid - half_ext;
        hi[a]    = mid + half_ext;
        // an inverted axis now and then
        if ($urandom_range(9) == 0) begin
          swap  = lo[a];
          lo[a] = hi[a];
          hi[a] = swap;
        end
      end
    end
    // mostly flags that reach the box test, with always cull toggling
    fl = ($urandom_range(3) != 0) ? ($urandom_range(1) ? F_ALWAYS : F_NONE)
                                  : 4'($urandom_range(15));
    box_test(fl, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  initial begin
    bit wild;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity matrix: clip space equals object space with w = 1 everywhere
    for (int r = 0; r < ROWS; r++) begin
      load_row(2'(r), (r == 0) ? ONE : '0, (r == 1) ? ONE : '0,
               (r == 2) ? ONE : '0, (r == 3) ? ONE : '0);
    end
    // fully inside, then one box past each plane, then past three at once
    box_test(F_NONE, -HALF, -HALF, QUARTER, HALF, HALF, HALF);
    box_test(F_NONE, TWO, -HALF, QUARTER, THREE, HALF, HALF);
    box_test(F_NONE, -THREE, -HALF, QUARTER, -TWO, HALF, HALF);
    box_test(F_NONE, -HALF, TWO, QUARTER, HALF, THREE, HALF);
    box_test(F_NONE, -HALF, -THREE, QUARTER, HALF, -TWO, HALF);
    box_test(F_NONE, -HALF, -HALF, TWO, HALF, HALF, THREE);
    box_test(F_NONE, -HALF, -HALF, -TWO, HALF, HALF, -ONE);
    box_test(F_NONE, TWO, TWO, TWO, THREE, THREE, THREE);
    // flat box sitting exactly on x = w is not outside
    box_test(F_NONE, ONE, -HALF, QUARTER, ONE, HALF, HALF);
    // flag precedence on a box that would cull
    box_test(F_HIDDEN, TWO, -HALF, QUARTER, THREE, HALF, HALF);
    box_test(F_DONT, TWO, -HALF, QUARTER, THREE, HALF, HALF);
    box_test(F_ALWAYS | F_HIDDEN | F_DONT, TWO, -HALF, QUARTER, THREE, HALF, HALF);
    box_test(F_EMPTY, TWO, -HALF, QUARTER, THREE, HALF, HALF);
    box_test(F_ALWAYS | F_EMPTY, TWO, -HALF, QUARTER, THREE, HALF, HALF);
    // extreme box bounds
    box_test(F_NONE, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
    // extreme matrix entries drive the accumulator to its widest sums
    for (int r = 0; r < ROWS; r++) begin
      load_row(2'(r), ((r & 1) != 0) ? MOST_POS : MOST_NEG,
               ((r & 1) == 0) ? MOST_POS : MOST_NEG,
               ((r & 1) != 0) ? MOST_POS : MOST_NEG,
               ((r & 1) == 0) ? MOST_POS : MOST_NEG);
    end
    box_test(F_NONE, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
    box_test(F_ALWAYS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS);

    // Random scenes: reload the whole matrix, then a run of boxes with occasional row reloads
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wild    = ($urandom_range(9) >= 7);
      idle_on = (items_sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(3) != 0);
      for (int r = 0; r < ROWS; r++) random_row(wild, 2'(r));
      repeat ($urandom_range(10, 40)) begin
        if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
        if ($urandom_range(9) == 0) random_row(wild, 2'($urandom_range(3)));
        else random_box(wild);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    // catch any stray strobe after the last expected result
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("box_frustum_cull_test_unit_tb: done, clean");
    end else begin
      $display("box_frustum_cull_test_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
